>>> design/lfr_pkg.sv
// Shared types and constants of the LIN frame receiver.
package lfr_pkg;

    localparam int STORE_DEPTH = 16;
    localparam int IDX_W       = $clog2(STORE_DEPTH);
    localparam int CNT_W       = 4;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic       REQ_BREAK    = 1'b0;
    localparam logic       REQ_BYTE     = 1'b1;
    localparam logic [1:0] DISCARD_INIT = 2'd2;
    localparam logic [7:0] BYTE_ONES    = 8'hFF;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_DISCARD = 3'd1,
        PH_ID      = 3'd2,
        PH_DATA    = 3'd3,
        PH_CHECK   = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        BK_IDLE  = 2'd0,
        BK_FETCH = 2'd1,
        BK_LOAD  = 2'd2,
        BK_SEND  = 2'd3
    } t_back_state;

    // One finished frame, handed from the front to the back.
    typedef struct packed {
        logic [7:0]       frame_id;
        logic [CNT_W-1:0] count;
        logic             checksum_ok;
    } t_frame_cmd;

    // Write port of the data byte store.
    typedef struct packed {
        logic             en;
        logic [CNT_W-1:0] addr;
        logic [7:0]       data;
    } t_store_wr;

    // Status of the frame queue as seen by the front.
    typedef struct packed {
        logic empty;
        logic full;
        logic back_busy;
    } t_queue_status;

endpackage

>>> design/lin_frame_receiver_unit.sv
// LIN frame receiver with classic checksum: front, frame queue and back.
//
// Items are LIN line events: a break (tuser 0) or a received byte (tuser 1).
// After a break two bytes are dropped, the next is the identifier whose low
// nibble minus one gives the data byte count, and the byte after the data is
// checked against the inverted carry-around sum. The front takes one item per
// cycle; a data byte stalls while the back still emits an earlier frame from
// the shared 16-byte store or one waits in the queue, and a checksum byte
// stalls while the two-entry frame queue is full. The back emits one result
// at a time (store read, output load, handshake) and takes the next frame from
// the queue only once the last is taken; an empty frame gives one result.
// A new break restarts reception at any time; there are no timeouts.
module lin_frame_receiver_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // rx_byte
    input  logic [0:0]  i_s_tuser,   // req_type
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // frame_id, byte_index, data_byte, zero fill
    output logic [1:0]  o_m_tuser,   // has_data, checksum_ok
    output logic        o_m_tlast    // last
);

    lfr_pkg::t_queue_status status;
    lfr_pkg::t_store_wr     store_wr;
    lfr_pkg::t_frame_cmd    push_cmd;
    lfr_pkg::t_frame_cmd    head_cmd;
    logic                   push;
    logic                   pop;
    logic                   q_empty;
    logic                   q_full;
    logic                   back_busy;

    assign status.empty     = q_empty;
    assign status.full      = q_full;
    assign status.back_busy = back_busy;

    lfr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_status   (status),
        .o_store_wr (store_wr),
        .o_push     (push),
        .o_cmd      (push_cmd)
    );

    lfr_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_head  (head_cmd),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    lfr_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_store_wr (store_wr),
        .i_head     (head_cmd),
        .i_empty    (q_empty),
        .o_pop      (pop),
        .o_busy     (back_busy),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

>>> design/lfr_front.sv
// Front end: tracks the LIN frame, stores data bytes, checks the checksum.
module lfr_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [7:0]            i_s_tdata,
    input  logic [0:0]            i_s_tuser,
    input  lfr_pkg::t_queue_status i_status,
    output lfr_pkg::t_store_wr    o_store_wr,
    output logic                  o_push,
    output lfr_pkg::t_frame_cmd   o_cmd
);

    lfr_pkg::t_phase              r_phase, n_phase;
    logic [1:0]                   r_discard, n_discard;
    logic [7:0]                   r_id, n_id;
    logic [lfr_pkg::CNT_W-1:0]    r_expected, n_expected;
    logic [lfr_pkg::CNT_W-1:0]    r_taken, n_taken;
    logic [7:0]                   r_sum, n_sum;

    logic                         is_byte;
    logic                         accept;
    logic [8:0]                   sum_wide;
    logic [lfr_pkg::CNT_W-1:0]    taken_inc;

    function automatic logic [lfr_pkg::CNT_W-1:0] data_count(
        input logic [lfr_pkg::CNT_W-1:0] expected
    );
        return (expected > lfr_pkg::CNT_W'(1)) ? expected - lfr_pkg::CNT_W'(1)
                                                : '0;
    endfunction

    assign is_byte   = (i_s_tuser[0] == lfr_pkg::REQ_BYTE);
    assign sum_wide  = {1'b0, r_sum} + {1'b0, i_s_tdata};
    assign taken_inc = r_taken + lfr_pkg::CNT_W'(1);

    // A data byte waits while the store still holds an earlier frame; a
    // checksum byte waits for room in the queue.
    always_comb begin
        o_s_tready = 1'b1;
        if (is_byte) begin
            if (r_phase == lfr_pkg::PH_DATA &&
                (i_status.back_busy || !i_status.empty)) begin
                o_s_tready = 1'b0;
            end else if (r_phase == lfr_pkg::PH_CHECK && i_status.full) begin
                o_s_tready = 1'b0;
            end
        end
    end

    assign accept = i_s_tvalid && o_s_tready;

    always_comb begin
        n_phase    = r_phase;
        n_discard  = r_discard;
        n_id       = r_id;
        n_expected = r_expected;
        n_taken    = r_taken;
        n_sum      = r_sum;
        o_store_wr = '0;
        o_push     = 1'b0;
        o_cmd.frame_id    = r_id;
        o_cmd.count       = r_taken;
        o_cmd.checksum_ok = (i_s_tdata == (lfr_pkg::BYTE_ONES - r_sum));
        if (accept) begin
            if (!is_byte) begin
                n_phase   = lfr_pkg::PH_DISCARD;
                n_discard = lfr_pkg::DISCARD_INIT;
                n_taken   = '0;
                n_sum     = '0;
            end else begin
                unique case (r_phase)
                    lfr_pkg::PH_IDLE: begin
                    end
                    lfr_pkg::PH_DISCARD: begin
                        if (r_discard != 2'd0) begin
                            n_discard = r_discard - 2'd1;
                        end
                        if (n_discard == 2'd0) begin
                            n_phase = lfr_pkg::PH_ID;
                        end
                    end
                    lfr_pkg::PH_ID: begin
                        n_id       = i_s_tdata;
                        n_expected = i_s_tdata[lfr_pkg::CNT_W-1:0];
                        n_taken    = '0;
                        n_sum      = '0;
                        n_phase    = (data_count(n_expected) == '0) ? lfr_pkg::PH_CHECK
                                                                     : lfr_pkg::PH_DATA;
                    end
                    lfr_pkg::PH_DATA: begin
                        o_store_wr.en   = 1'b1;
                        o_store_wr.addr = r_taken;
                        o_store_wr.data = i_s_tdata;
                        // Carry-around add: a carry out adds one back in.
                        n_sum   = sum_wide[8] ? sum_wide[7:0] + 8'd1 : sum_wide[7:0];
                        n_taken = taken_inc;
                        if (taken_inc >= data_count(r_expected)) begin
                            n_phase = lfr_pkg::PH_CHECK;
                        end
                    end
                    lfr_pkg::PH_CHECK: begin
                        o_push  = 1'b1;
                        n_phase = lfr_pkg::PH_IDLE;
                    end
                    default: begin
                        n_phase = lfr_pkg::PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= lfr_pkg::PH_IDLE;
            r_discard  <= '0;
            r_id       <= '0;
            r_expected <= '0;
            r_taken    <= '0;
            r_sum      <= '0;
        end else begin
            r_phase    <= n_phase;
            r_discard  <= n_discard;
            r_id       <= n_id;
            r_expected <= n_expected;
            r_taken    <= n_taken;
            r_sum      <= n_sum;
        end
    end

endmodule

>>> design/lfr_cmd_fifo.sv
// Short queue of finished frames between the front and the back.
module lfr_cmd_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  lfr_pkg::t_frame_cmd i_cmd,
    input  logic                i_pop,
    output lfr_pkg::t_frame_cmd o_head,
    output logic                o_empty,
    output logic                o_full
);

    lfr_pkg::t_frame_cmd         r_mem [lfr_pkg::QUEUE_DEPTH];
    logic [lfr_pkg::QPTR_W-1:0]  r_wr_ptr;
    logic [lfr_pkg::QPTR_W-1:0]  r_rd_ptr;
    logic [lfr_pkg::QPTR_W:0]    r_fill;
    logic                        do_push;
    logic                        do_pop;

    assign o_empty = (r_fill == '0);
    assign o_full  = (r_fill == (lfr_pkg::QPTR_W+1)'(lfr_pkg::QUEUE_DEPTH));
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + lfr_pkg::QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + lfr_pkg::QPTR_W'(1);
            end
            r_fill <= r_fill + (lfr_pkg::QPTR_W+1)'(do_push)
                             - (lfr_pkg::QPTR_W+1)'(do_pop);
        end
    end

endmodule

>>> design/lfr_back.sv
// Back end: holds the data byte store and emits the results of each frame.
module lfr_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lfr_pkg::t_store_wr  i_store_wr,
    input  lfr_pkg::t_frame_cmd i_head,
    input  logic                i_empty,
    output logic                o_pop,
    output logic                o_busy,
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    output logic [23:0]         o_m_tdata,
    output logic [1:0]          o_m_tuser,
    output logic                o_m_tlast
);

    logic [7:0]                r_store [lfr_pkg::STORE_DEPTH];
    logic [7:0]                r_rd_data;

    lfr_pkg::t_back_state      r_state, n_state;
    lfr_pkg::t_frame_cmd       r_cmd, n_cmd;
    logic [lfr_pkg::CNT_W-1:0] r_k, n_k;
    logic                      r_valid, n_valid;
    logic                      n_load;
    logic                      has_data;
    logic                      is_last;
    logic [lfr_pkg::CNT_W-1:0] k_inc;

    logic [7:0]                r_frame_id;
    logic [lfr_pkg::CNT_W-1:0] r_index;
    logic [7:0]                r_data;
    logic                      r_has_data;
    logic                      r_ok;
    logic                      r_last;

    always_ff @(posedge i_clk) begin
        if (i_store_wr.en) begin
            r_store[lfr_pkg::IDX_W'(i_store_wr.addr)] <= i_store_wr.data;
        end
        r_rd_data <= r_store[lfr_pkg::IDX_W'(r_k)];
    end

    assign has_data = (r_cmd.count != '0);
    assign k_inc    = r_k + lfr_pkg::CNT_W'(1);
    assign is_last  = !has_data || (k_inc == r_cmd.count);
    assign o_busy   = (r_state != lfr_pkg::BK_IDLE);

    always_comb begin
        n_state = r_state;
        n_cmd   = r_cmd;
        n_k     = r_k;
        n_valid = r_valid;
        n_load  = 1'b0;
        o_pop   = 1'b0;
        unique case (r_state)
            lfr_pkg::BK_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_cmd   = i_head;
                    n_k     = '0;
                    n_state = lfr_pkg::BK_FETCH;
                end
            end
            lfr_pkg::BK_FETCH: begin
                n_state = lfr_pkg::BK_LOAD;
            end
            lfr_pkg::BK_LOAD: begin
                n_load  = 1'b1;
                n_valid = 1'b1;
                n_state = lfr_pkg::BK_SEND;
            end
            lfr_pkg::BK_SEND: begin
                if (i_m_tready) begin
                    n_valid = 1'b0;
                    if (r_last) begin
                        n_state = lfr_pkg::BK_IDLE;
                    end else begin
                        n_k     = k_inc;
                        n_state = lfr_pkg::BK_FETCH;
                    end
                end
            end
            default: begin
                n_state = lfr_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lfr_pkg::BK_IDLE;
            r_valid <= 1'b0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_k     <= n_k;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        if (n_load) begin
            r_frame_id <= r_cmd.frame_id;
            r_index    <= has_data ? r_k : '0;
            r_data     <= (has_data && r_cmd.checksum_ok) ? r_rd_data : 8'd0;
            r_has_data <= has_data;
            r_ok       <= r_cmd.checksum_ok;
            r_last     <= is_last;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = {4'd0, r_data, r_index, r_frame_id};
    assign o_m_tuser  = {r_ok, r_has_data};
    assign o_m_tlast  = r_last;

endmodule

>>> design/lfr_checker.sv
// Port-level checks of the LIN frame receiver, bound to the top level.
module lfr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_m_tvalid,
    input logic        i_m_tready,
    input logic [23:0] i_m_tdata,
    input logic [1:0]  i_m_tuser,
    input logic        i_m_tlast
);

    // A result that waits must not change.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> i_m_tvalid && $stable(i_m_tdata)
            && $stable(i_m_tuser) && $stable(i_m_tlast))
        else $error("result changed while stalled");

    // The single result of an empty frame is the last one, at index zero.
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tuser[0] |-> i_m_tlast && (i_m_tdata[19:8] == 12'd0))
        else $error("malformed empty-frame result");

    // A failed checksum zeroes every data byte.
    a_bad_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tuser[1] |-> (i_m_tdata[19:12] == 8'd0))
        else $error("data byte passed with failed checksum");

    // After the final result of a frame is taken, the output is not valid in the cycle after.
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && i_m_tready && i_m_tlast |=> !i_m_tvalid)
        else $error("result shown right after frame end");

endmodule

bind lin_frame_receiver_unit lfr_checker u_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .i_m_tdata  (o_m_tdata),
    .i_m_tuser  (o_m_tuser),
    .i_m_tlast  (o_m_tlast)
);
